[sv/onewire_scratchpad_temperature_check_top_assert.svh]
// Assertion macros used by the scratchpad check RTL.
`ifndef ONEWIRE_SCRATCHPAD_TEMPERATURE_CHECK_TOP_ASSERT_SVH
`define ONEWIRE_SCRATCHPAD_TEMPERATURE_CHECK_TOP_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define OWTC_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("owtc: invariant violated");

// When trig holds, cond must hold in the next cycle.
`define OWTC_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("owtc: sequence violated");

`endif

[sv/owtc_pkg.sv]
// Types, constants and the CRC-8 byte step for the scratchpad check.
package owtc_pkg;

    localparam logic [7:0]        MarkerValue = 8'h10;
    localparam logic signed [15:0] FailTemp   = -16'sd27315;
    localparam logic [3:0]        CrcLen      = 4'd8;
    localparam logic [7:0]        PolyRefl    = 8'h8C;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } owtc_item_t;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic               valid_res;
    } owtc_result_t;

    // Handshake between the stages and the check logic
    typedef struct packed {
        logic advance;   // stage-one transaction moves on this cycle
        logic emit;      // that transaction yields a result
    } owtc_ctrl_t;

    // Dallas/Maxim CRC-8, reflected, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ PolyRefl) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[sv/owtc_in_stage.sv]
// Input register stage: holds one accepted byte transaction.
module owtc_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  owtc_pkg::owtc_item_t in_item,
    input  owtc_pkg::owtc_ctrl_t ctrl,
    output logic               s1_valid,
    output owtc_pkg::owtc_item_t s1_item
);
    import owtc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    owtc_item_t item_reg;
    logic       load;

    // Hold off the sender while the held byte cannot move on
    assign in_stall = valid_reg && !ctrl.advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (ctrl.advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

[sv/owtc_check.sv]
// Scratchpad state: CRC, byte position, raw reading, marker and conversion.
module owtc_check (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s1_valid,
    input  owtc_pkg::owtc_item_t   s1_item,
    input  logic                   advance,
    output logic                   emit,
    output owtc_pkg::owtc_result_t result
);
    import owtc_pkg::*;

    `include "onewire_scratchpad_temperature_check_top_assert.svh"

    logic [7:0] crc_reg,    crc_next;
    logic [3:0] pos_reg,    pos_next;
    logic [7:0] raw_lo_reg, raw_lo_next;
    logic [7:0] raw_hi_reg, raw_hi_next;
    logic       marker_reg, marker_next;

    logic [3:0]         pos_eff;
    logic [7:0]         crc_base;
    logic               ok;
    logic signed [15:0] raw;
    logic signed [15:0] raw_x6;
    logic signed [15:0] raw_q4;

    // Effective position: restart or a stray position counts as byte 0
    assign pos_eff  = (s1_item.restart || pos_reg > CrcLen) ? 4'd0 : pos_reg;
    assign crc_base = (pos_eff == 4'd0) ? 8'd0 : crc_reg;
    assign emit     = s1_valid && (pos_eff == CrcLen);

    // State update per byte
    always_comb
    begin
        crc_next    = crc_reg;
        pos_next    = pos_reg;
        raw_lo_next = raw_lo_reg;
        raw_hi_next = raw_hi_reg;
        marker_next = marker_reg;
        if (advance)
        begin
            if (pos_eff == CrcLen)
            begin
                crc_next = crc_base;
                pos_next = 4'd0;
            end
            else
            begin
                crc_next = crc8_byte(crc_base, s1_item.data_byte);
                pos_next = pos_eff + 4'd1;
                if (pos_eff == 4'd0)
                    raw_lo_next = s1_item.data_byte;
                if (pos_eff == 4'd1)
                    raw_hi_next = s1_item.data_byte;
                if (pos_eff == 4'd7)
                    marker_next = (s1_item.data_byte == MarkerValue);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= '0;
            pos_reg    <= '0;
            raw_lo_reg <= '0;
            raw_hi_reg <= '0;
            marker_reg <= 1'b0;
        end
        else
        begin
            crc_reg    <= crc_next;
            pos_reg    <= pos_next;
            raw_lo_reg <= raw_lo_next;
            raw_hi_reg <= raw_hi_next;
            marker_reg <= marker_next;
        end
    end

    // Check and conversion: r*6 + r/4, quotient truncated toward zero
    assign ok     = (crc_reg == s1_item.data_byte) && marker_reg;
    assign raw    = $signed({raw_hi_reg, raw_lo_reg});
    assign raw_x6 = (raw <<< 2) + (raw <<< 1);
    assign raw_q4 = (raw + (raw[15] ? 16'sd3 : 16'sd0)) >>> 2;

    always_comb
    begin
        result.valid_res   = ok;
        result.temperature = ok ? (raw_x6 + raw_q4) : FailTemp;
    end

    `OWTC_ASSERT_ALWAYS(a_pos_range, pos_reg <= CrcLen)
    `OWTC_ASSERT_NEXT(a_emit_wraps, advance && emit, pos_reg == 4'd0)
    `OWTC_ASSERT_NEXT(a_byte_counts, advance && !emit, pos_reg != 4'd0)
    `OWTC_ASSERT_NEXT(a_restart_pos, advance && s1_item.restart, pos_reg == 4'd1)

endmodule

[sv/owtc_out_stage.sv]
// Result register: holds one finished result until the receiver takes it.
module owtc_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  owtc_pkg::owtc_ctrl_t   ctrl,
    input  owtc_pkg::owtc_result_t result,
    output logic                   out_free,
    output logic                   out_valid,
    input  logic                   out_stall,
    output owtc_pkg::owtc_result_t out_result
);
    import owtc_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    owtc_result_t result_reg;
    logic         load;

    // Register can take a new result if empty or draining this cycle
    assign out_free = !valid_reg || !out_stall;
    assign load     = ctrl.advance && ctrl.emit;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

[sv/onewire_scratchpad_temperature_check_top.sv]
// Top level of the 1-Wire scratchpad CRC check and temperature conversion.
//
// Input channel (in_valid/in_stall, data_byte, restart) carries the nine
// scratchpad bytes in order; restart marks byte 0 of a new scratchpad.
// Bytes 0 to 7 feed the CRC-8 and yield no result. Byte 8 yields one result
// transaction on the output channel (out_valid/out_stall, temperature,
// valid_res): hundredths of a degree if CRC and marker byte matched, else
// -27315 with valid_res low. After byte 8 the count wraps to byte 0.
// Throughput: one byte per cycle while in_stall is low. A byte goes
// through an input register, then one combinational pass (CRC step, check,
// r*6 + r/4) into the result register.
// When the receiver stalls, the result register holds; bytes that give no
// result still flow, and in_stall rises only when a byte-8 transaction is
// waiting behind a full, stalled result register.
// Reset clears the byte count, CRC, raw reading, marker and both valids.
module onewire_scratchpad_temperature_check_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] temperature,
    output logic               valid_res
);
    import owtc_pkg::*;

    owtc_item_t   in_item;
    owtc_item_t   s1_item;
    logic         s1_valid;
    owtc_ctrl_t   ctrl;
    logic         emit;
    logic         out_free;
    owtc_result_t result;
    owtc_result_t out_result;

    assign in_item.data_byte = data_byte;
    assign in_item.restart   = restart;

    // Stage one moves on unless its result has nowhere to go
    assign ctrl.emit    = emit;
    assign ctrl.advance = s1_valid && (!emit || out_free);

    owtc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .ctrl     (ctrl),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    owtc_check u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .advance  (ctrl.advance),
        .emit     (emit),
        .result   (result)
    );

    owtc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign temperature = out_result.temperature;
    assign valid_res   = out_result.valid_res;

endmodule
